[hw/rtl/bdlp_pkg.sv]
// shared constants and types for the button debounce and long-press block
package bdlp_pkg;

   localparam int HOLD_MS          = 500;
   localparam int TICK_MS          = 10;
   localparam int NUM_BUTTONS_DEF  = 4;
   localparam int LEVEL_BITS       = 4;
   localparam int TICKS_W          = 16;
   localparam int REQ_TDATA_W      = 8;
   localparam int RSP_TDATA_W      = 16;

   localparam logic [TICKS_W-1:0] LONG_PRESS_RESET = TICKS_W'(HOLD_MS / TICK_MS);

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef struct packed {
      logic tick;
      logic clear;
   } lane_ctrl_type;

endpackage

[hw/rtl/bdlp_lane.sv]
// one button: three-sample debounce, hold countdown and sticky flags
module bdlp_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  bdlp_pkg::lane_ctrl_type       ctrl,
   input  logic                          sample,
   input  logic [bdlp_pkg::TICKS_W-1:0]  ticks,
   output logic                          press_pending,
   output logic                          long_pending
);

   logic [1:0]                      hist_ff, hist_in;
   logic                            stable_ff, stable_in;
   logic [bdlp_pkg::TICKS_W-1:0]    count_ff, count_in;
   logic                            press_ff, press_in;
   logic                            long_ff, long_in;
   logic                            next_lvl;
   logic [bdlp_pkg::TICKS_W-1:0]    count_step;

   always_comb begin
      hist_in    = hist_ff;
      stable_in  = stable_ff;
      count_in   = count_ff;
      press_in   = press_ff;
      long_in    = long_ff;
      count_step = count_ff;
      // level only moves when the two older samples and this one agree
      next_lvl   = ((hist_ff[1] == hist_ff[0]) && (hist_ff[0] == sample)) ? sample : stable_ff;
      if (ctrl.tick) begin
         hist_in = {hist_ff[0], sample};
         if (next_lvl != stable_ff) begin
            stable_in  = next_lvl;
            count_step = ticks;
         end else if (!stable_ff && (count_ff != '0)) begin
            count_step = count_ff - 1'b1;
         end
         count_in = count_step;
         if (!stable_in) begin
            if (count_step >= ticks) begin
               press_in = 1'b1;
            end else if (count_step == '0) begin
               long_in  = 1'b1;
               count_in = ticks;
            end
         end
      end else if (ctrl.clear) begin
         press_in = 1'b0;
         long_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff   <= 2'b11;
         stable_ff <= 1'b1;
         count_ff  <= bdlp_pkg::LONG_PRESS_RESET;
         press_ff  <= 1'b0;
         long_ff   <= 1'b0;
      end else begin
         hist_ff   <= hist_in;
         stable_ff <= stable_in;
         count_ff  <= count_in;
         press_ff  <= press_in;
         long_ff   <= long_in;
      end
   end

   assign press_pending = press_ff;
   assign long_pending  = long_ff;

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (ctrl.clear && !ctrl.tick) |=> (!press_ff && !long_ff))
      else $error("flags survive a read");

   a_release_no_flag: assert property (@(posedge clock) disable iff (reset)
      (ctrl.tick && stable_in && !press_ff && !long_ff) |=> (!press_ff && !long_ff))
      else $error("flag raised while released");

endmodule

[hw/rtl/bdlp_merge.sv]
// combines lane flags into the response word and holds it in the output register
module bdlp_merge #(
   parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              mode,
   input  logic [NUM_BUTTONS-1:0]            press_vec,
   input  logic [NUM_BUTTONS-1:0]            long_vec,
   output logic                              ready,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bdlp_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   logic [bdlp_pkg::LEVEL_BITS-1:0]   press_bits, long_bits;
   logic                              any_bit;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bdlp_pkg::RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   // lanes past the levels field count toward any_flag only
   for (genvar j = 0; j < bdlp_pkg::LEVEL_BITS; j++) begin : g_bits
      if (j < NUM_BUTTONS) begin : g_live
         assign press_bits[j] = press_vec[j];
         assign long_bits[j]  = long_vec[j];
      end else begin : g_none
         assign press_bits[j] = 1'b0;
         assign long_bits[j]  = 1'b0;
      end
   end

   assign any_bit = (|press_vec) | (|long_vec);
   assign ready   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         if (mode == bdlp_pkg::MODE_READ) begin
            rsp_data_in = {(bdlp_pkg::RSP_TDATA_W - 2 * bdlp_pkg::LEVEL_BITS - 1)'(0),
                           any_bit, long_bits, press_bits};
         end else begin
            rsp_data_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word not presented");

   a_tick_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && mode == bdlp_pkg::MODE_TICK) |=> (rsp_data_ff == '0))
      else $error("tick word carries flags");

   a_read_any: assert property (@(posedge clock) disable iff (reset)
      (accept && mode == bdlp_pkg::MODE_READ) |=>
         (rsp_data_ff[2*bdlp_pkg::LEVEL_BITS] == $past(any_bit)))
      else $error("any_flag mismatch");

endmodule

[hw/rtl/button_debounce_long_press.sv]
// top level: debounce and long-press detection for a bank of active-low buttons
//
// req channel: req_tuser is the mode (0 tick, 1 read and clear), req_tdata[3:0]
// the raw levels, one bit per button, 0 = pressed. every accepted word gives
// exactly one rsp word: a tick returns all zeros, a read returns the pending
// press flags (rsp_tdata[3:0]), long-press flags ([7:4]) and any_flag ([8]),
// then clears all flags. buttons past the levels field see a released level.
// csr_wr_en with csr_wr_data sets the countdown reload; write it while idle.
// rsp_tvalid rises in the cycle after acceptance. one word per cycle is
// taken: all button lanes update in parallel in that cycle and the response
// sits in a single output register. when the receiver stalls, the register
// holds its word and req_tready drops until it is taken (req_tready follows
// rsp_tready combinationally). reset: all buttons released, flags cleared,
// countdowns and the reload at 50 ticks, no response pending.
module button_debounce_long_press #(
   parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [bdlp_pkg::TICKS_W-1:0]      csr_wr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bdlp_pkg::REQ_TDATA_W-1:0]  req_tdata,   // [3:0] levels
   input  logic                              req_tuser,   // [0] mode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bdlp_pkg::RSP_TDATA_W-1:0]  rsp_tdata    // [3:0] press_flags, [7:4] long_press_flags, [8] any_flag
);

   logic [bdlp_pkg::TICKS_W-1:0]  ticks_ff;
   logic                          accept;
   bdlp_pkg::lane_ctrl_type       lane_ctrl;
   logic [NUM_BUTTONS-1:0]        press_vec, long_vec;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= bdlp_pkg::LONG_PRESS_RESET;
      end else if (csr_wr_en) begin
         ticks_ff <= csr_wr_data;
      end
   end

   assign accept          = req_tvalid && req_tready;
   assign lane_ctrl.tick  = accept && (req_tuser == bdlp_pkg::MODE_TICK);
   assign lane_ctrl.clear = accept && (req_tuser == bdlp_pkg::MODE_READ);

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      logic sample;
      if (i < bdlp_pkg::LEVEL_BITS) begin : g_in
         assign sample = req_tdata[i];
      end else begin : g_out
         assign sample = 1'b1;
      end
      bdlp_lane u_lane (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (lane_ctrl),
         .sample        (sample),
         .ticks         (ticks_ff),
         .press_pending (press_vec[i]),
         .long_pending  (long_vec[i])
      );
   end

   bdlp_merge #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .mode       (req_tuser),
      .press_vec  (press_vec),
      .long_vec   (long_vec),
      .ready      (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[tb/button_debounce_long_press_tb.sv]
// testbench for the button debounce and long-press block: random and directed words
module button_debounce_long_press_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BTN         = bdlp_pkg::NUM_BUTTONS_DEF;
   localparam int HOLD_OFF_CYCLES = 40;
   localparam int DRAIN_CYCLES    = 10;

   typedef struct {
      logic       mode;
      logic [3:0] levels;
   } btn_word_type;

   typedef struct {
      logic [3:0] press_flags;
      logic [3:0] long_flags;
      logic       any_flag;
   } flag_word_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_wr_en = 1'b0;
   logic [bdlp_pkg::TICKS_W-1:0]        csr_wr_data = '0;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [bdlp_pkg::REQ_TDATA_W-1:0]    req_tdata = '0;   // [3:0] levels
   logic                                req_tuser = bdlp_pkg::MODE_TICK;   // [0] mode
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   // [3:0] press_flags, [7:4] long_press_flags, [8] any_flag
   logic [bdlp_pkg::RSP_TDATA_W-1:0]    rsp_tdata;

   // button model state
   logic [1:0]                    hist_q [NUM_BTN];
   logic                          stable_q [NUM_BTN];
   logic [bdlp_pkg::TICKS_W-1:0]  countdown_q [NUM_BTN];
   logic                          press_pend [NUM_BTN];
   logic                          long_pend [NUM_BTN];
   logic [bdlp_pkg::TICKS_W-1:0]  reload_ticks;

   btn_word_type  words_pending [$];
   flag_word_type flags_expected [$];
   btn_word_type  cur_word;

   int   req_max_gap = 5;
   int   rsp_max_wait = 5;
   int   gap_left;
   int   rsp_wait;
   int   hold_off_count = 0;
   int   hold_off_seen = 0;
   int   fail_count = 0;
   int   words_sent = 0;
   int   reads_sent = 0;
   int   press_seen = 0;
   int   long_seen = 0;
   int   reload_writes = 0;
   logic [3:0] target_lv = 4'hf;

   button_debounce_long_press u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void reset_button_model();
      reload_ticks = bdlp_pkg::LONG_PRESS_RESET;
      for (int i = 0; i < NUM_BTN; i++) begin
         hist_q[i]      = 2'b11;
         stable_q[i]    = 1'b1;
         countdown_q[i] = bdlp_pkg::LONG_PRESS_RESET;
         press_pend[i]  = 1'b0;
         long_pend[i]   = 1'b0;
      end
   endfunction

   function automatic flag_word_type debounce_predict(input btn_word_type w);
      flag_word_type r;
      logic          smp;
      logic          nxt;
      r = '{press_flags: 4'h0, long_flags: 4'h0, any_flag: 1'b0};
      for (int i = 0; i < NUM_BTN; i++) begin
         if (w.mode == bdlp_pkg::MODE_TICK) begin
            // buttons past the levels field stay released
            smp = (i < bdlp_pkg::LEVEL_BITS) ? w.levels[i] : 1'b1;
            nxt = stable_q[i];
            if (hist_q[i][1] == hist_q[i][0] && hist_q[i][0] == smp)
               nxt = smp;
            hist_q[i] = {hist_q[i][0], smp};
            if (nxt != stable_q[i]) begin
               stable_q[i]    = nxt;
               countdown_q[i] = reload_ticks;
            end else if (stable_q[i] == 1'b0 && countdown_q[i] != 0) begin
               countdown_q[i] = countdown_q[i] - 1'b1;
            end
            if (stable_q[i] == 1'b0) begin
               if (countdown_q[i] >= reload_ticks) begin
                  press_pend[i] = 1'b1;
               end else if (countdown_q[i] == 0) begin
                  long_pend[i]   = 1'b1;
                  countdown_q[i] = reload_ticks;
               end
            end
         end else begin
            if (press_pend[i] || long_pend[i])
               r.any_flag = 1'b1;
            if (i < bdlp_pkg::LEVEL_BITS) begin
               r.press_flags[i] = press_pend[i];
               r.long_flags[i]  = long_pend[i];
            end
            press_pend[i] = 1'b0;
            long_pend[i]  = 1'b0;
         end
      end
      return r;
   endfunction

   // driver: one word per handshake, random gap after each accepted word
   always @(posedge clock) begin
      if (reset) begin
         reset_button_model();
         gap_left = 0;
         req_tvalid <= 1'b0;
      end else begin
         if (csr_wr_en)
            reload_ticks = csr_wr_data;
         if (req_tvalid && req_tready) begin
            flags_expected.push_back(debounce_predict(cur_word));
            gap_left = $urandom_range(0, req_max_gap);
            words_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left == 0 && words_pending.size() != 0) begin
               cur_word = words_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= (bdlp_pkg::REQ_TDATA_W)'(cur_word.levels);
               req_tuser  <= cur_word.mode;
            end else begin
               if (gap_left != 0)
                  gap_left--;
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compares each response word and paces rsp_tready
   always @(posedge clock) begin
      if (reset) begin
         rsp_wait = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (flags_expected.size() == 0) begin
               $error("unexpected response word 0x%0h", rsp_tdata);
               fail_count++;
            end else begin
               flag_word_type exp_w;
               exp_w = flags_expected.pop_front();
               if (rsp_tdata[3:0] !== exp_w.press_flags) begin
                  $error("press_flags: expected 0x%0h, got 0x%0h",
                         exp_w.press_flags, rsp_tdata[3:0]);
                  fail_count++;
               end
               if (rsp_tdata[7:4] !== exp_w.long_flags) begin
                  $error("long_press_flags: expected 0x%0h, got 0x%0h",
                         exp_w.long_flags, rsp_tdata[7:4]);
                  fail_count++;
               end
               if (rsp_tdata[8] !== exp_w.any_flag) begin
                  $error("any_flag: expected %0d, got %0d", exp_w.any_flag, rsp_tdata[8]);
                  fail_count++;
               end
               press_seen += $countones(exp_w.press_flags);
               long_seen  += $countones(exp_w.long_flags);
            end
            rsp_wait = $urandom_range(0, rsp_max_wait);
         end
         if (hold_off_seen != hold_off_count) begin
            hold_off_seen = hold_off_count;
            rsp_wait = HOLD_OFF_CYCLES;
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic wait_idle();
      do
         @(negedge clock);
      while (words_pending.size() != 0 || flags_expected.size() != 0 || req_tvalid ||
             rsp_tvalid);
   endtask

   task automatic write_reload(input logic [bdlp_pkg::TICKS_W-1:0] value);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      reload_writes++;
      @(negedge clock);
   endtask

   task automatic push_word(input logic mode, input logic [3:0] levels, input int count = 1);
      btn_word_type w;
      w.mode   = mode;
      w.levels = levels;
      repeat (count) begin
         words_pending.push_back(w);
         if (mode == bdlp_pkg::MODE_READ)
            reads_sent++;
      end
   endtask

   // bouncy hold/release patterns with some pure noise and reads at random
   task automatic push_random_words(input int count);
      logic [3:0] lv;
      repeat (count) begin
         if ($urandom_range(0, 4) == 0) begin
            push_word(bdlp_pkg::MODE_READ, 4'($urandom));
         end else begin
            if ($urandom_range(0, 4) == 0) begin
               lv = 4'($urandom);
            end else begin
               if ($urandom_range(0, 9) == 0)
                  target_lv = 4'($urandom);
               lv = target_lv;
               if ($urandom_range(0, 5) == 0)
                  lv ^= 4'($urandom) & 4'($urandom);
            end
            push_word(bdlp_pkg::MODE_TICK, lv);
         end
      end
   endtask

   initial begin
      logic [bdlp_pkg::TICKS_W-1:0] reload_list [8];
      reload_list = '{16'd1, 16'hffff, 16'd3, 16'd2, 16'd5, 16'd50, 16'd7, 16'd4};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset reload: read at reset, presses on all buttons, then on pairs of buttons
      push_word(bdlp_pkg::MODE_READ, 4'hf);
      push_word(bdlp_pkg::MODE_TICK, 4'hf);
      push_word(bdlp_pkg::MODE_TICK, 4'h0, 3);
      push_word(bdlp_pkg::MODE_READ, 4'h0);
      push_word(bdlp_pkg::MODE_TICK, 4'h5, 3);
      push_word(bdlp_pkg::MODE_READ, 4'h5);
      push_word(bdlp_pkg::MODE_TICK, 4'ha, 3);
      push_word(bdlp_pkg::MODE_READ, 4'ha);

      // lowered reload while buttons are held: countdown sits above the reload
      write_reload(16'd2);
      push_word(bdlp_pkg::MODE_TICK, 4'h0, 4);
      push_word(bdlp_pkg::MODE_READ, 4'hf);

      // reload of zero, then full release
      write_reload(16'd0);
      push_word(bdlp_pkg::MODE_TICK, 4'h0, 2);
      push_word(bdlp_pkg::MODE_READ, 4'h0);
      push_word(bdlp_pkg::MODE_TICK, 4'hf, 3);
      push_word(bdlp_pkg::MODE_READ, 4'hf);

      for (int p = 0; p < 8; p++) begin
         write_reload(reload_list[p]);
         case (p)
            1: begin
               req_max_gap  = 0;
               rsp_max_wait = 0;
            end
            2: begin
               // sender keeps offering while the receiver holds off
               req_max_gap  = 0;
               rsp_max_wait = 5;
               @(posedge clock);
               hold_off_count <= hold_off_count + 1;
               @(negedge clock);
            end
            default: begin
               req_max_gap  = 5;
               rsp_max_wait = 5;
            end
         endcase
         push_random_words(60);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (flags_expected.size() != 0) begin
         $error("%0d response words never arrived", flags_expected.size());
         fail_count++;
      end
      $display("run covered %0d words (%0d reads) over %0d reload settings",
               words_sent, reads_sent, reload_writes + 1);
      $display("flags returned: %0d press, %0d long-press", press_seen, long_seen);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
